### hw/rtl/assert_macros.svh
// Assertion macros used by the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### hw/rtl/ght_pkg.sv
// Package of types and constants for the generational handle table.
package ght_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned OWNERS_DEF = 16;
	localparam logic [15:0] GEN_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_OPEN = 3'd0,
		ACT_GET = 3'd1,
		ACT_CLOSE = 3'd2,
		ACT_DETACH_OWNER = 3'd3,
		ACT_DETACH_AUTH = 3'd4,
		ACT_FINISH_OWNER = 3'd5,
		ACT_FINISH_AUTH = 3'd6,
		ACT_BAD = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SWEEP,
		FSM_EMIT,
		FSM_WAIT
	} fsm_t;
endpackage

### hw/rtl/generational_handle_table.sv
// Generational handle table: slot store, free list and sweep sequencer.
// Each word is accepted while the block is idle and is worked in a sweep state before its
// result is presented; the block takes no new word until the last result of the current
// one has been taken, and it returns to the idle state before the next word is accepted.
// Open, get, close and unknown actions pass once through the sweep state and then present
// their result. Detach actions visit every slot, one a cycle, through a single shared
// compare unit, and present their one result once the last slot has been visited.
// Finish actions visit the slots in index order and present one word per cleared slot,
// each held until the consumer takes it; a look-ahead over the remaining slots marks the
// final hit as last and ends the sweep there. With no hit, all SLOTS slots are visited
// and one word is presented. Slot state lives in flip-flops.
module generational_handle_table #(
	parameter int unsigned SLOTS = ght_pkg::SLOTS_DEF,
	parameter int unsigned OWNERS = ght_pkg::OWNERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [3:0]  owner,
	input  logic [15:0] handle_index,
	input  logic [15:0] handle_generation,
	input  logic [3:0]  type_req,
	input  logic [15:0] authority,
	input  logic [31:0] resource_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] out_index,
	output logic [15:0] out_generation,
	output logic [31:0] out_tag,
	output logic [4:0]  owner_total,
	output logic [4:0]  table_total,
	output logic [4:0]  peak_total,
	output logic        finished,
	output logic        last
);
	import ght_pkg::*;
`include "assert_macros.svh"

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [4:0] FREE_NONE = 5'd31;

	logic [SLOTS-1:0] occ_q, closing_q, retired_q;
	logic [15:0] gen_q [SLOTS];
	logic [4:0]  next_q [SLOTS];
	logic [3:0]  sowner_q [SLOTS];
	logic [3:0]  stype_q [SLOTS];
	logic [15:0] sauth_q [SLOTS];
	logic [31:0] stag_q [SLOTS];
	logic [4:0]  head_q, occ_cnt_q, peak_q;
	logic [4:0]  ocnt_q [OWNERS];

	fsm_t state_q, state_d;
	action_t act_q;
	logic [3:0]  own_q;
	logic [15:0] hidx_q, hgen_q, auth_q;
	logic [3:0]  type_q;
	logic [31:0] rtag_q;
	logic [IW-1:0] ptr_q;

	logic [1:0]  st_q;
	logic [15:0] oidx_q, ogen_q;
	logic [31:0] otag_q;
	logic        fin_q, last_q;

	logic own_ok;
	logic [4:0] own_cnt;
	logic idx_ok;
	logic [IW-1:0] hsel, hsel_full;
	logic look_hit;
	logic match;
	logic sweep_end;

	assign own_ok = (32'(own_q) < OWNERS);
	assign own_cnt = own_ok ? ocnt_q[own_q[$clog2(OWNERS > 1 ? OWNERS : 2)-1:0]] : 5'd0;
	assign idx_ok = (32'(hidx_q) < SLOTS);
	assign hsel_full = hidx_q[IW-1:0];
	assign hsel = idx_ok ? hsel_full : '0;
	assign look_hit = occ_q[hsel] && gen_q[hsel] == hgen_q && sowner_q[hsel] == own_q;
	assign sweep_end = (32'(ptr_q) == SLOTS - 1);

	always_comb begin
		case (act_q)
			ACT_DETACH_OWNER, ACT_DETACH_AUTH: match = occ_q[ptr_q] && sowner_q[ptr_q] == own_q
				&& (act_q == ACT_DETACH_OWNER || sauth_q[ptr_q] == auth_q);
			ACT_FINISH_OWNER, ACT_FINISH_AUTH: match = closing_q[ptr_q]
				&& sowner_q[ptr_q] == own_q
				&& (act_q == ACT_FINISH_OWNER || sauth_q[ptr_q] == auth_q);
			default: match = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FSM_SWEEP;
				end
			end
			FSM_SWEEP: begin
				case (act_q)
					ACT_DETACH_OWNER, ACT_DETACH_AUTH: begin
						if (sweep_end) begin
							state_d = FSM_EMIT;
						end
					end
					ACT_FINISH_OWNER, ACT_FINISH_AUTH: begin
						if (match) begin
							state_d = FSM_WAIT;
						end else if (sweep_end) begin
							state_d = FSM_EMIT;
						end
					end
					default: state_d = FSM_EMIT;
				endcase
			end
			FSM_EMIT: begin
				if (out_ready) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_WAIT: begin
				if (out_ready) begin
					state_d = last_q ? FSM_IDLE : FSM_SWEEP;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign out_valid = (state_q == FSM_EMIT) || (state_q == FSM_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			closing_q <= '0;
			retired_q <= '0;
			head_q <= '0;
			occ_cnt_q <= '0;
			peak_q <= '0;
			ptr_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				gen_q[i] <= 16'd1;
				next_q[i] <= (i + 1 < SLOTS) ? 5'(i + 1) : FREE_NONE;
				sowner_q[i] <= '0;
				stype_q[i] <= '0;
				sauth_q[i] <= '0;
				stag_q[i] <= '0;
			end
			for (int j = 0; j < OWNERS; j++) begin
				ocnt_q[j] <= '0;
			end
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (in_valid) begin
						ptr_q <= '0;
					end
				end
				FSM_SWEEP: begin
					case (act_q)
						ACT_OPEN: begin
							if (type_q != '0 && own_ok && 32'(head_q) < SLOTS) begin
								occ_q[head_q[IW-1:0]] <= 1'b1;
								sowner_q[head_q[IW-1:0]] <= own_q;
								stype_q[head_q[IW-1:0]] <= type_q;
								sauth_q[head_q[IW-1:0]] <= auth_q;
								stag_q[head_q[IW-1:0]] <= rtag_q;
								head_q <= next_q[head_q[IW-1:0]];
								ocnt_q[own_q[$clog2(OWNERS > 1 ? OWNERS : 2)-1:0]] <= own_cnt + 5'd1;
								occ_cnt_q <= occ_cnt_q + 5'd1;
								if (occ_cnt_q + 5'd1 > peak_q) begin
									peak_q <= occ_cnt_q + 5'd1;
								end
							end
						end
						ACT_CLOSE: begin
							if (idx_ok && look_hit) begin
								occ_q[hsel] <= 1'b0;
								closing_q[hsel] <= 1'b0;
								if (own_cnt != '0) begin
									ocnt_q[own_q[$clog2(OWNERS > 1 ? OWNERS : 2)-1:0]] <= own_cnt - 5'd1;
								end
								if (occ_cnt_q != '0) begin
									occ_cnt_q <= occ_cnt_q - 5'd1;
								end
								if (gen_q[hsel] == GEN_MAX) begin
									retired_q[hsel] <= 1'b1;
								end else begin
									gen_q[hsel] <= gen_q[hsel] + 16'd1;
									next_q[hsel] <= head_q;
									head_q <= 5'(hsel);
								end
								sowner_q[hsel] <= '0;
								stype_q[hsel] <= '0;
								sauth_q[hsel] <= '0;
								stag_q[hsel] <= '0;
							end
						end
						ACT_DETACH_OWNER, ACT_DETACH_AUTH: begin
							ptr_q <= ptr_q + 1'b1;
							if (match) begin
								occ_q[ptr_q] <= 1'b0;
								closing_q[ptr_q] <= 1'b1;
								if (own_ok && own_cnt != '0) begin
									ocnt_q[own_q[$clog2(OWNERS > 1 ? OWNERS : 2)-1:0]] <= own_cnt - 5'd1;
								end
								if (occ_cnt_q != '0) begin
									occ_cnt_q <= occ_cnt_q - 5'd1;
								end
								if (gen_q[ptr_q] == GEN_MAX) begin
									retired_q[ptr_q] <= 1'b1;
								end else begin
									gen_q[ptr_q] <= gen_q[ptr_q] + 16'd1;
									next_q[ptr_q] <= head_q;
									head_q <= 5'(ptr_q);
								end
							end
						end
						ACT_FINISH_OWNER, ACT_FINISH_AUTH: begin
							if (match) begin
								closing_q[ptr_q] <= 1'b0;
								sowner_q[ptr_q] <= '0;
								stype_q[ptr_q] <= '0;
								sauth_q[ptr_q] <= '0;
								stag_q[ptr_q] <= '0;
							end
							if (!sweep_end) begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Input capture and result register. A finish hit looks ahead for a further match in
	// the remaining slots, so that the final hit carries last.
	logic more_hits;
	always_comb begin
		more_hits = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (i > ptr_q && closing_q[i] && sowner_q[i] == own_q
				&& (act_q == ACT_FINISH_OWNER || sauth_q[i] == auth_q)) begin
				more_hits = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && in_valid) begin
			act_q <= action_t'(action);
			own_q <= owner;
			hidx_q <= handle_index;
			hgen_q <= handle_generation;
			type_q <= type_req;
			auth_q <= authority;
			rtag_q <= resource_tag;
		end
		if (state_q == FSM_SWEEP) begin
			st_q <= ST_OK;
			oidx_q <= '0;
			ogen_q <= '0;
			otag_q <= '0;
			fin_q <= 1'b0;
			last_q <= 1'b1;
			case (act_q)
				ACT_OPEN: begin
					if (type_q == '0 || !own_ok) begin
						st_q <= ST_INVALID;
					end else if (32'(head_q) >= SLOTS) begin
						st_q <= ST_LIMIT;
					end else begin
						oidx_q <= 16'(head_q);
						ogen_q <= gen_q[head_q[IW-1:0]];
					end
				end
				ACT_GET: begin
					if (type_q == '0 || !idx_ok) begin
						st_q <= ST_INVALID;
					end else if (!look_hit || stype_q[hsel] != type_q) begin
						st_q <= ST_NOT_FOUND;
					end else begin
						otag_q <= stag_q[hsel];
					end
				end
				ACT_CLOSE: begin
					if (!idx_ok) begin
						st_q <= ST_INVALID;
					end else if (!look_hit) begin
						st_q <= ST_NOT_FOUND;
					end else begin
						oidx_q <= hidx_q;
						otag_q <= stag_q[hsel];
						fin_q <= 1'b1;
					end
				end
				ACT_FINISH_OWNER, ACT_FINISH_AUTH: begin
					if (match) begin
						oidx_q <= 16'(ptr_q);
						otag_q <= stag_q[ptr_q];
						fin_q <= 1'b1;
						last_q <= !more_hits;
					end
				end
				ACT_BAD: st_q <= ST_INVALID;
				default: ;
			endcase
		end
	end

	assign status = st_q;
	assign out_index = oidx_q;
	assign out_generation = ogen_q;
	assign out_tag = otag_q;
	assign owner_total = own_cnt;
	assign table_total = occ_cnt_q;
	assign peak_total = peak_q;
	assign finished = fin_q;
	assign last = last_q;

	`ASSERT_ALWAYS(a_peak_ge_occ, clk, arst_n, peak_q >= occ_cnt_q, "peak below occupancy")
	`ASSERT_IMPL(a_no_ready_busy, clk, arst_n, out_valid, !in_ready, "ready while a result waits")
	`ASSERT_IMPL(a_emit_last, clk, arst_n, state_q == FSM_EMIT, last_q, "single result not last")
	`ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1, 32'(occ_cnt_q) <= SLOTS, "occupancy overflow")
endmodule

### dv/tb_top.sv
// Self-checking testbench for the generational handle table: random and directed words, scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import ght_pkg::*;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  owner;
		logic [15:0] hidx;
		logic [15:0] hgen;
		logic [3:0]  typ;
		logic [15:0] auth;
		logic [31:0] tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] index;
		logic [15:0] gen;
		logic [31:0] tag;
		logic [4:0]  otot;
		logic [4:0]  ttot;
		logic [4:0]  ptot;
		logic        fin;
		logic        last;
	} rsp_t;

	localparam int NS = 16;
	localparam logic [4:0] NONE = 5'd31;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic [3:0] owner = '0;
	logic [15:0] handle_index = '0;
	logic [15:0] handle_generation = '0;
	logic [3:0] type_req = '0;
	logic [15:0] authority = '0;
	logic [31:0] resource_tag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [15:0] out_index, out_generation;
	logic [31:0] out_tag;
	logic [4:0] owner_total, table_total, peak_total;
	logic finished, last;

	generational_handle_table u_top (.*);

	always #10 clk = ~clk;

	logic        m_occ[NS], m_cls[NS], m_ret[NS];
	logic [15:0] m_gen[NS], m_auth[NS];
	logic [4:0]  m_next[NS];
	logic [3:0]  m_own[NS], m_typ[NS];
	logic [31:0] m_tag[NS];
	logic [4:0]  m_head, m_occn, m_peak;
	logic [4:0]  m_ocnt[16];

	req_t pending_words[$];
	rsp_t expected_words[$];
	int errors = 0;
	int sent = 0;
	int results_seen = 0;
	bit quiet = 0;
	bit hold = 0;
	int in_gap = 0, out_gap = 0;
	int idle_cycles = 0;

	task automatic free_slot(input int o, input int i);
		if (m_occ[i]) begin
			m_occ[i] = 0;
			m_cls[i] = 1;
			if (m_ocnt[o] != 0) m_ocnt[o]--;
			if (m_occn != 0) m_occn--;
			if (m_gen[i] == GEN_MAX) begin
				m_ret[i] = 1;
			end else begin
				m_gen[i]++;
				m_next[i] = m_head;
				m_head = i[4:0];
			end
		end
	endtask

	function automatic logic [31:0] wipe_slot(input int i);
		logic [31:0] t;
		t = m_tag[i];
		m_tag[i] = 0;
		m_auth[i] = 0;
		m_own[i] = 0;
		m_typ[i] = 0;
		m_cls[i] = 0;
		return t;
	endfunction

	function automatic rsp_t mk(input status_t s, input logic [15:0] ix,
			input logic [15:0] g, input logic [31:0] t, input logic f);
		rsp_t r;
		r = '0;
		r.status = s;
		r.index = ix;
		r.gen = g;
		r.tag = t;
		r.fin = f;
		return r;
	endfunction

	task automatic predict_table(input req_t w);
		rsp_t res[$];
		rsp_t r;
		int i;
		status_t st;
		res = {};
		case (action_t'(w.action))
			ACT_OPEN: begin
				if (w.typ == 0) begin
					res.push_back(mk(ST_INVALID, 0, 0, 0, 0));
				end else if (m_head >= NS) begin
					res.push_back(mk(ST_LIMIT, 0, 0, 0, 0));
				end else begin
					i = m_head;
					m_head = m_next[i];
					m_occ[i] = 1;
					m_own[i] = w.owner;
					m_typ[i] = w.typ;
					m_auth[i] = w.auth;
					m_tag[i] = w.tag;
					m_ocnt[w.owner]++;
					m_occn++;
					if (m_occn > m_peak) m_peak = m_occn;
					res.push_back(mk(ST_OK, i[15:0], m_gen[i], 0, 0));
				end
			end
			ACT_GET, ACT_CLOSE: begin
				if (w.action == ACT_GET && w.typ == 0) begin
					st = ST_INVALID;
				end else if (w.hidx >= NS) begin
					st = ST_INVALID;
				end else if (!m_occ[w.hidx] || m_gen[w.hidx] != w.hgen ||
						m_own[w.hidx] != w.owner) begin
					st = ST_NOT_FOUND;
				end else if (w.action == ACT_GET && m_typ[w.hidx] != w.typ) begin
					st = ST_NOT_FOUND;
				end else begin
					st = ST_OK;
				end
				if (st != ST_OK) begin
					res.push_back(mk(st, 0, 0, 0, 0));
				end else if (w.action == ACT_GET) begin
					res.push_back(mk(ST_OK, 0, 0, m_tag[w.hidx], 0));
				end else begin
					free_slot(w.owner, w.hidx);
					res.push_back(mk(ST_OK, w.hidx, 0, wipe_slot(w.hidx), 1));
				end
			end
			ACT_DETACH_OWNER, ACT_DETACH_AUTH: begin
				for (i = 0; i < NS; i++)
					if (m_occ[i] && m_own[i] == w.owner &&
							(w.action == ACT_DETACH_OWNER || m_auth[i] == w.auth))
						free_slot(w.owner, i);
				res.push_back(mk(ST_OK, 0, 0, 0, 0));
			end
			ACT_FINISH_OWNER, ACT_FINISH_AUTH: begin
				for (i = 0; i < NS; i++)
					if (m_cls[i] && m_own[i] == w.owner &&
							(w.action == ACT_FINISH_OWNER || m_auth[i] == w.auth))
						res.push_back(mk(ST_OK, i[15:0], 0, wipe_slot(i), 1));
				if (res.size() == 0) res.push_back(mk(ST_OK, 0, 0, 0, 0));
			end
			default: res.push_back(mk(ST_INVALID, 0, 0, 0, 0));
		endcase
		for (i = 0; i < res.size(); i++) begin
			r = res[i];
			r.otot = m_ocnt[w.owner];
			r.ttot = m_occn;
			r.ptot = m_peak;
			r.last = (i == res.size() - 1);
			expected_words.push_back(r);
		end
	endtask

	function automatic req_t rnd_word();
		req_t w;
		int s;
		w.action = $urandom_range(0, 99) < 3 ? ACT_BAD : 3'($urandom_range(0, 6));
		if ($urandom_range(0, 2) == 0 && w.action <= ACT_CLOSE) w.action = ACT_OPEN;
		w.owner = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
		s = $urandom_range(0, NS - 1);
		if ($urandom_range(0, 9) == 0) begin
			w.hidx = 16'($urandom);
			w.hgen = 16'($urandom);
		end else begin
			w.hidx = 16'(s);
			w.hgen = m_gen[s] + ($urandom_range(0, 7) == 0);
			if (m_occ[s] && $urandom_range(0, 3) != 0) w.owner = m_own[s];
		end
		w.typ = $urandom_range(0, 15) == 0 ? 4'd0 : 4'($urandom_range(1, 3));
		if (w.action == ACT_GET && m_occ[s] && $urandom_range(0, 1)) w.typ = m_typ[s];
		w.auth = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2));
		if (m_occ[s] && $urandom_range(0, 1)) w.auth = m_auth[s];
		w.tag = $urandom;
		return w;
	endfunction

	function automatic req_t dw(input action_t a, input logic [3:0] o, input logic [15:0] ix,
			input logic [15:0] g, input logic [3:0] t, input logic [15:0] au);
		req_t w;
		w.action = a;
		w.owner = o;
		w.hidx = ix;
		w.hgen = g;
		w.typ = t;
		w.auth = au;
		w.tag = $urandom;
		return w;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_table(pending_words.pop_front());
				sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) in_gap--;
				if (pending_words.size() > 0 && in_gap == 0 && !hold &&
						!(in_valid && in_ready && pending_words.size() == 0)) begin
					in_valid <= 1'b1;
					{action, owner, handle_index, handle_generation, type_req,
						authority, resource_tag} <= pending_words[0];
					if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 13);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		rsp_t a;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				a = {status, out_index, out_generation, out_tag, owner_total,
					table_total, peak_total, finished, last};
				results_seen++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", a);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (a.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, a.status); errors++; end
					if (a.index !== e.index) begin
						$error("out_index exp %0d got %0d", e.index, a.index); errors++; end
					if (a.gen !== e.gen) begin
						$error("out_generation exp %0d got %0d", e.gen, a.gen); errors++; end
					if (a.tag !== e.tag) begin
						$error("out_tag exp %h got %h", e.tag, a.tag); errors++; end
					if (a.otot !== e.otot) begin
						$error("owner_total exp %0d got %0d", e.otot, a.otot); errors++; end
					if (a.ttot !== e.ttot) begin
						$error("table_total exp %0d got %0d", e.ttot, a.ttot); errors++; end
					if (a.ptot !== e.ptot) begin
						$error("peak_total exp %0d got %0d", e.ptot, a.ptot); errors++; end
					if (a.fin !== e.fin) begin
						$error("finished exp %0d got %0d", e.fin, a.fin); errors++; end
					if (a.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, a.last); errors++; end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 2000) begin
				$display("watchdog expired, %0d words outstanding", expected_words.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int i, n;
		for (i = 0; i < NS; i++) begin
			m_occ[i] = 0; m_cls[i] = 0; m_ret[i] = 0; m_gen[i] = 1;
			m_next[i] = (i + 1 < NS) ? 5'(i + 1) : NONE;
			m_own[i] = 0; m_typ[i] = 0; m_auth[i] = 0; m_tag[i] = 0;
		end
		for (i = 0; i < 16; i++) m_ocnt[i] = 0;
		m_head = 0; m_occn = 0; m_peak = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: invalid cases, full table and finish after detach.
		pending_words.push_back(dw(ACT_OPEN, 4'd15, 0, 0, 4'd0, 0));
		pending_words.push_back(dw(ACT_BAD, 0, 0, 0, 1, 0));
		pending_words.push_back(dw(ACT_GET, 0, 16'hFFFF, 1, 1, 0));
		pending_words.push_back(dw(ACT_GET, 0, 0, 1, 4'd0, 0));
		for (i = 0; i < NS + 1; i++)
			pending_words.push_back(dw(ACT_OPEN, 4'(i % 2 ? 15 : 0), 0, 0, 4'd15, 16'(i % 2)));
		pending_words.push_back(dw(ACT_GET, 0, 0, 1, 4'd15, 0));
		pending_words.push_back(dw(ACT_CLOSE, 0, 0, 16'hFFFF, 1, 0));
		pending_words.push_back(dw(ACT_CLOSE, 0, 2, 1, 1, 0));
		pending_words.push_back(dw(ACT_DETACH_AUTH, 15, 0, 0, 1, 16'd1));
		pending_words.push_back(dw(ACT_FINISH_AUTH, 15, 0, 0, 1, 16'd1));
		pending_words.push_back(dw(ACT_DETACH_OWNER, 0, 0, 0, 1, 0));
		pending_words.push_back(dw(ACT_FINISH_OWNER, 0, 0, 0, 1, 0));
		pending_words.push_back(dw(ACT_FINISH_OWNER, 0, 0, 0, 1, 0));

		for (n = 0; n < 200; n++) begin
			wait (pending_words.size() == 0);
			if (n == 100) begin
				hold = 1;
				wait (expected_words.size() == 0);
				@(posedge clk);
				hold = 0;
			end
			if (n == 170) quiet = 1;
			pending_words.push_back(rnd_word());
			@(posedge clk);
		end
		wait (pending_words.size() == 0 && expected_words.size() == 0);
		repeat (40) @(posedge clk);
		$display("%0d words sent, %0d result words checked, peak occupancy %0d",
			sent, results_seen, m_peak);
		$display("covered open to full table, stale and foreign handles, sweeps and finishes");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

### generational_handle_table.f
+incdir+hw/rtl
hw/rtl/ght_pkg.sv
hw/rtl/generational_handle_table.sv
dv/tb_top.sv
